### rtl/kdtlt_pkg.sv
// Package for the keypad debounce / tap / long-press tracker.
// Holds operation codes, register indexes, reset values and the
// controller-datapath command and status types. No dependencies.
package kdtlt_pkg;

    localparam int NUM_KEYS_DEF = 16;
    localparam int FIELD_KEYS   = 16;

    localparam logic [1:0] OP_SCAN = 2'd0;
    localparam logic [1:0] OP_MARK = 2'd1;
    localparam logic [1:0] OP_ACK  = 2'd2;

    localparam logic [1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [1:0] CFG_TAP      = 2'd1;
    localparam logic [1:0] CFG_LONG     = 2'd2;

    localparam logic [15:0] DEBOUNCE_RST = 16'd8;
    localparam logic [15:0] TAP_RST      = 16'd450;
    localparam logic [15:0] LONG_RST     = 16'd600;

    typedef struct packed {
        logic load_in;
        logic apply_op;
        logic step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic is_scan;
        logic last_key;
    } t_stat;

endpackage

### rtl/keypad_debounce_tap_long_tracker.sv
// Channel   Direction  Handshake               Word
// in        sink       i_in_valid / o_in_stall  operation, raw keys, time, ack masks
// out       source     o_out_valid / i_out_stall key state masks, held key
// cfg       sink       i_cfg_valid / o_cfg_ready register index, 16-bit data
//
// A scan word is walked to its end before the next word is accepted: the
// keys go one per cycle through a single update unit, fed by the stamp
// memories one key ahead. Mark and acknowledge act on the key state in one step.
// The result sits in an output register and is held while i_out_stall is
// high; a finished word waits for that register before the next is taken.
// Reset (synchronous, i_rst_n low) clears all key state; stamps read as
// zero until written. Top level of the tracker; depends on kdtlt_pkg,
// kdtlt_ctrl and kdtlt_datapath.
module keypad_debounce_tap_long_tracker import kdtlt_pkg::*; #(
    parameter int NUM_KEYS = NUM_KEYS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [15:0] i_raw_keys,
    input  logic [31:0] i_now_ms,
    input  logic [15:0] i_ack_tap_mask,
    input  logic [15:0] i_ack_long_mask,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_down_mask,
    output logic [15:0] o_tap_mask,
    output logic [15:0] o_long_mask,
    output logic        o_held_valid,
    output logic [3:0]  o_held_key
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    kdtlt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    kdtlt_datapath #(
        .NUM_KEYS (NUM_KEYS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_operation     (i_operation),
        .i_raw_keys      (i_raw_keys),
        .i_now_ms        (i_now_ms),
        .i_ack_tap_mask  (i_ack_tap_mask),
        .i_ack_long_mask (i_ack_long_mask),
        .o_down_mask     (o_down_mask),
        .o_tap_mask      (o_tap_mask),
        .o_long_mask     (o_long_mask),
        .o_held_valid    (o_held_valid),
        .o_held_key      (o_held_key)
    );

endmodule

### rtl/kdtlt_ctrl.sv
// Sequencer for the tracker: accepts a word, walks the keys one per cycle
// for a scan word and hands the result to the output register.
// Depends on kdtlt_pkg.
module kdtlt_ctrl import kdtlt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    output logic  o_out_valid,
    input  logic  i_out_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PRIME = 2'd1;
    localparam logic [1:0] S_RUN   = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_PRIME;
                end
            end
            S_PRIME: begin
                // non-scan words finish here in one step
                if (i_stat.is_scan) begin
                    n_state = S_RUN;
                end else begin
                    o_cmd.apply_op = 1'b1;
                    n_state        = S_DONE;
                end
            end
            S_RUN: begin
                o_cmd.step = 1'b1;
                if (i_stat.last_key) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### rtl/kdtlt_datapath.sv
// Datapath for the tracker: configuration registers, key state, the two
// time-stamp memories, the per-key update unit and the output register.
// Depends on kdtlt_pkg.
module kdtlt_datapath import kdtlt_pkg::*; #(
    parameter int NUM_KEYS = NUM_KEYS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic [1:0]  i_operation,
    input  logic [15:0] i_raw_keys,
    input  logic [31:0] i_now_ms,
    input  logic [15:0] i_ack_tap_mask,
    input  logic [15:0] i_ack_long_mask,
    output logic [15:0] o_down_mask,
    output logic [15:0] o_tap_mask,
    output logic [15:0] o_long_mask,
    output logic        o_held_valid,
    output logic [3:0]  o_held_key
);

    localparam int KW     = $clog2(NUM_KEYS);
    localparam int KEY_IN = (NUM_KEYS < FIELD_KEYS) ? NUM_KEYS : FIELD_KEYS;
    localparam int HW     = (KW > 4) ? KW : 4;
    localparam logic [KW-1:0] LAST_KEY = KW'(NUM_KEYS - 1);

    logic [15:0] r_deb, r_tap_t, r_long_t;

    logic [1:0]          r_op;
    logic [NUM_KEYS-1:0] r_raw, r_ack_tap, r_ack_long;
    logic [31:0]         r_now;
    logic [KW-1:0]       r_key;

    logic [NUM_KEYS-1:0] r_stable, n_stable;
    logic [NUM_KEYS-1:0] r_last, n_last;
    logic [NUM_KEYS-1:0] r_tapf, n_tapf;
    logic [NUM_KEYS-1:0] r_longf, n_longf;
    logic [NUM_KEYS-1:0] r_ldone, n_ldone;
    logic [NUM_KEYS-1:0] r_mod, n_mod;
    logic                r_held_p, n_held_p;
    logic [KW-1:0]       r_held_idx, n_held_idx;

    logic [31:0]         cs_mem [NUM_KEYS];
    logic [31:0]         ps_mem [NUM_KEYS];
    logic [NUM_KEYS-1:0] r_cs_vld, r_ps_vld;
    logic [31:0]         r_rd_cs, r_rd_ps;
    logic [KW-1:0]       rd_addr;

    logic [NUM_KEYS-1:0] raw_ext, ack_tap_ext, ack_long_ext;
    logic                k_down, k_chg, k_deb_ok, k_flip, k_press, k_rel;
    logic                k_st_new, k_ld_new, k_md_new, k_tap_set, k_long_set;
    logic [31:0]         cs_age, ps_age;
    logic [NUM_KEYS-1:0] fb_cand;
    logic                fb_any;
    logic [KW-1:0]       fb_idx;
    logic [HW-1:0]       held_w;

    logic [15:0] r_out_down, r_out_tap, r_out_long;
    logic        r_out_hv;
    logic [3:0]  r_out_hk;

    // fit 16-bit port masks to the key count; keys past the field read as up
    always_comb begin
        raw_ext                   = '0;
        ack_tap_ext               = '0;
        ack_long_ext              = '0;
        raw_ext[KEY_IN-1:0]       = i_raw_keys[KEY_IN-1:0];
        ack_tap_ext[KEY_IN-1:0]   = i_ack_tap_mask[KEY_IN-1:0];
        ack_long_ext[KEY_IN-1:0]  = i_ack_long_mask[KEY_IN-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deb    <= DEBOUNCE_RST;
            r_tap_t  <= TAP_RST;
            r_long_t <= LONG_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEBOUNCE: r_deb    <= i_cfg_data;
                CFG_TAP:      r_tap_t  <= i_cfg_data;
                CFG_LONG:     r_long_t <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op       <= i_operation;
            r_raw      <= raw_ext;
            r_now      <= i_now_ms;
            r_ack_tap  <= ack_tap_ext;
            r_ack_long <= ack_long_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cmd.load_in) begin
            r_key <= '0;
        end else if (i_cmd.step) begin
            r_key <= (r_key == LAST_KEY) ? '0 : r_key + 1'b1;
        end
    end

    assign o_stat.is_scan  = (r_op == OP_SCAN);
    assign o_stat.last_key = (r_key == LAST_KEY);

    // fetch the next key's stamps while the current key is updated
    assign rd_addr = (i_cmd.step && r_key != LAST_KEY) ? r_key + 1'b1 : '0;

    always_ff @(posedge i_clk) begin
        r_rd_cs <= r_cs_vld[rd_addr] ? cs_mem[rd_addr] : '0;
        r_rd_ps <= r_ps_vld[rd_addr] ? ps_mem[rd_addr] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && k_chg) begin
            cs_mem[r_key] <= r_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && k_press) begin
            ps_mem[r_key] <= r_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cs_vld <= '0;
            r_ps_vld <= '0;
        end else if (i_cmd.step) begin
            if (k_chg) begin
                r_cs_vld[r_key] <= 1'b1;
            end
            if (k_press) begin
                r_ps_vld[r_key] <= 1'b1;
            end
        end
    end

    // per-key update
    assign cs_age = r_now - r_rd_cs;
    assign ps_age = r_now - r_rd_ps;

    always_comb begin
        k_down   = r_raw[r_key];
        k_chg    = (k_down != r_last[r_key]);
        // a fresh edge has zero age
        k_deb_ok = k_chg ? (r_deb == 16'd0) : (cs_age >= {16'd0, r_deb});
        k_flip   = k_deb_ok && (k_down != r_stable[r_key]);
        k_press  = k_flip && k_down;
        k_rel    = k_flip && !k_down;
        k_st_new = r_stable[r_key] ^ k_flip;
        k_ld_new = k_press ? 1'b0 : r_ldone[r_key];
        k_md_new = k_press ? 1'b0 : r_mod[r_key];
        k_tap_set = k_rel && !r_ldone[r_key] && !r_mod[r_key] &&
                    (ps_age < {16'd0, r_tap_t});
        k_long_set = k_st_new && !k_ld_new && !k_md_new &&
                     (k_press ? (r_long_t == 16'd0) : (ps_age >= {16'd0, r_long_t}));
    end

    // lowest down key once the current key has dropped
    always_comb begin
        fb_cand        = r_stable;
        fb_cand[r_key] = 1'b0;
        fb_any         = 1'b0;
        fb_idx         = '0;
        for (int j = NUM_KEYS - 1; j >= 0; j--) begin
            if (fb_cand[j]) begin
                fb_any = 1'b1;
                fb_idx = KW'(j);
            end
        end
    end

    always_comb begin
        n_stable   = r_stable;
        n_last     = r_last;
        n_tapf     = r_tapf;
        n_longf    = r_longf;
        n_ldone    = r_ldone;
        n_mod      = r_mod;
        n_held_p   = r_held_p;
        n_held_idx = r_held_idx;
        if (i_cmd.step) begin
            n_last[r_key]   = k_down;
            n_stable[r_key] = k_st_new;
            n_mod[r_key]    = k_md_new;
            n_ldone[r_key]  = k_ld_new | k_long_set;
            if (k_tap_set) begin
                n_tapf[r_key] = 1'b1;
            end
            if (k_long_set) begin
                n_longf[r_key] = 1'b1;
            end
            if (k_press) begin
                n_held_p   = 1'b1;
                n_held_idx = r_key;
            end else if (k_rel && r_held_p && r_held_idx == r_key) begin
                n_held_p = fb_any;
                if (fb_any) begin
                    n_held_idx = fb_idx;
                end
            end
        end else if (i_cmd.apply_op) begin
            case (r_op)
                OP_MARK: begin
                    n_mod   = r_mod | r_stable;
                    n_ldone = r_ldone | r_stable;
                end
                OP_ACK: begin
                    n_tapf  = r_tapf & ~r_ack_tap;
                    n_longf = r_longf & ~r_ack_long;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable   <= '0;
            r_last     <= '0;
            r_tapf     <= '0;
            r_longf    <= '0;
            r_ldone    <= '0;
            r_mod      <= '0;
            r_held_p   <= 1'b0;
            r_held_idx <= '0;
        end else begin
            r_stable   <= n_stable;
            r_last     <= n_last;
            r_tapf     <= n_tapf;
            r_longf    <= n_longf;
            r_ldone    <= n_ldone;
            r_mod      <= n_mod;
            r_held_p   <= n_held_p;
            r_held_idx <= n_held_idx;
        end
    end

    assign held_w = HW'(r_held_idx);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_down <= 16'(r_stable[KEY_IN-1:0]);
            r_out_tap  <= 16'(r_tapf[KEY_IN-1:0]);
            r_out_long <= 16'(r_longf[KEY_IN-1:0]);
            r_out_hv   <= r_held_p;
            r_out_hk   <= r_held_p ? held_w[3:0] : 4'd0;
        end
    end

    assign o_down_mask  = r_out_down;
    assign o_tap_mask   = r_out_tap;
    assign o_long_mask  = r_out_long;
    assign o_held_valid = r_out_hv;
    assign o_held_key   = r_out_hk;

endmodule

### tb/testbench.sv
// Self-checking testbench for keypad_debounce_tap_long_tracker: directed and random
// scan, mark and acknowledge words against a cycle-free predictor of the key state.
// Depends on kdtlt_pkg and the tracker RTL.
`timescale 1ns / 1ps

module testbench;
    import kdtlt_pkg::*;

    localparam int KEYS = NUM_KEYS_DEF;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = KEYS + 12;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] raw;
        logic [31:0] now;
        logic [15:0] ack_tap;
        logic [15:0] ack_long;
    } t_key_word;

    typedef struct packed {
        logic [15:0] down_mask;
        logic [15:0] tap_mask;
        logic [15:0] long_mask;
        logic        held_valid;
        logic [3:0]  held_key;
    } t_key_state;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_index = CFG_DEBOUNCE;
    logic [15:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    t_key_word   in_word = '0;
    logic        i_out_stall = 1'b0;
    logic        o_cfg_ready, o_in_stall, o_out_valid, o_held_valid;
    logic [15:0] o_down_mask, o_tap_mask, o_long_mask;
    logic [3:0]  o_held_key;

    keypad_debounce_tap_long_tracker u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (in_word.op),
        .i_raw_keys      (in_word.raw),
        .i_now_ms        (in_word.now),
        .i_ack_tap_mask  (in_word.ack_tap),
        .i_ack_long_mask (in_word.ack_long),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_down_mask     (o_down_mask),
        .o_tap_mask      (o_tap_mask),
        .o_long_mask     (o_long_mask),
        .o_held_valid    (o_held_valid),
        .o_held_key      (o_held_key)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Predictor copy of the registers and key state
    logic [15:0] reg_debounce = DEBOUNCE_RST;
    logic [15:0] reg_tap = TAP_RST;
    logic [15:0] reg_long = LONG_RST;
    logic [15:0] key_stable = '0;
    logic [15:0] key_last_raw = '0;
    logic [31:0] key_change_at [KEYS];
    logic [31:0] key_press_at [KEYS];
    logic [15:0] key_tap = '0;
    logic [15:0] key_long = '0;
    logic [15:0] key_long_done = '0;
    logic [15:0] key_modifier = '0;
    logic        key_held_v = 1'b0;
    logic [3:0]  key_held_k = '0;

    initial begin
        for (int k = 0; k < KEYS; k++) begin
            key_change_at[k] = '0;
            key_press_at[k] = '0;
        end
    end

    t_key_word  pending_words [$];
    t_key_state expected_states [$];
    int send_idle_pct = 0;
    int stall_pct = 0;
    int errors = 0;
    logic [15:0] gen_raw = '0;
    logic [31:0] gen_now = '0;

    function automatic t_key_state next_key_state(input t_key_word w);
        logic [31:0] since_change;
        logic [31:0] since_press;
        logic        pressed;
        logic        found;
        t_key_state  r;
        case (w.op)
            OP_SCAN: begin
                for (int k = 0; k < KEYS; k++) begin
                    pressed = w.raw[k];
                    if (pressed != key_last_raw[k]) begin
                        key_last_raw[k] = pressed;
                        key_change_at[k] = w.now;
                    end
                    since_change = w.now - key_change_at[k];
                    if (since_change >= {16'd0, reg_debounce} && pressed != key_stable[k]) begin
                        key_stable[k] = pressed;
                        if (pressed) begin
                            key_press_at[k] = w.now;
                            key_long_done[k] = 1'b0;
                            key_modifier[k] = 1'b0;
                            key_held_v = 1'b1;
                            key_held_k = 4'(k);
                        end else begin
                            since_press = w.now - key_press_at[k];
                            if (!key_long_done[k] && !key_modifier[k] &&
                                since_press < {16'd0, reg_tap})
                                key_tap[k] = 1'b1;
                            // fall back to the lowest key down; higher keys not yet updated
                            if (key_held_v && key_held_k == 4'(k)) begin
                                key_held_v = 1'b0;
                                found = 1'b0;
                                for (int j = 0; j < KEYS; j++) begin
                                    if (!found && key_stable[j]) begin
                                        found = 1'b1;
                                        key_held_v = 1'b1;
                                        key_held_k = 4'(j);
                                    end
                                end
                            end
                        end
                    end
                    since_press = w.now - key_press_at[k];
                    if (key_stable[k] && !key_long_done[k] && !key_modifier[k] &&
                        since_press >= {16'd0, reg_long}) begin
                        key_long_done[k] = 1'b1;
                        key_long[k] = 1'b1;
                    end
                end
            end
            OP_MARK: begin
                key_modifier = key_modifier | key_stable;
                key_long_done = key_long_done | key_stable;
            end
            OP_ACK: begin
                key_tap = key_tap & ~w.ack_tap;
                key_long = key_long & ~w.ack_long;
            end
            default: ;
        endcase
        r.down_mask = key_stable;
        r.tap_mask = key_tap;
        r.long_mask = key_long;
        r.held_valid = key_held_v;
        r.held_key = key_held_v ? key_held_k : 4'd0;
        return r;
    endfunction

    // Driver: hold a stalled word, otherwise advance or idle
    always @(posedge i_clk) begin : drive_words
        t_key_word nxt;
        if (i_rst_n && (!i_in_valid || !o_in_stall)) begin
            if (i_in_valid)
                expected_states.push_back(next_key_state(in_word));
            if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                nxt = pending_words.pop_front();
                in_word <= nxt;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each accepted result word against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_key_state want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_states.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result word: down=%h tap=%h long=%h held=%b/%0d",
                             o_down_mask, o_tap_mask, o_long_mask, o_held_valid,
                             o_held_key);
            end else begin
                want = expected_states.pop_front();
                if (o_down_mask !== want.down_mask || o_tap_mask !== want.tap_mask ||
                    o_long_mask !== want.long_mask || o_held_valid !== want.held_valid ||
                    o_held_key !== want.held_key) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display({"mismatch: expected down=%h tap=%h long=%h held=%b/%0d,",
                                  " got down=%h tap=%h long=%h held=%b/%0d"},
                                 want.down_mask, want.tap_mask, want.long_mask,
                                 want.held_valid, want.held_key, o_down_mask, o_tap_mask,
                                 o_long_mask, o_held_valid, o_held_key);
                end
            end
        end
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    task automatic push_word(input logic [1:0] op, input logic [15:0] raw,
                             input logic [31:0] now, input logic [15:0] ack_tap,
                             input logic [15:0] ack_long);
        t_key_word w;
        w.op = op;
        w.raw = raw;
        w.now = now;
        w.ack_tap = ack_tap;
        w.ack_long = ack_long;
        pending_words.push_back(w);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_DEBOUNCE: reg_debounce = val;
            CFG_TAP:      reg_tap = val;
            CFG_LONG:     reg_long = val;
            default: ;
        endcase
    endtask

    task automatic wait_drain();
        @(negedge i_clk);
        while (pending_words.size() != 0 || i_in_valid || expected_states.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic random_words(input int count);
        t_key_word w;
        int pick;
        repeat (count) begin
            w.raw = 16'($urandom);
            w.now = $urandom;
            w.ack_tap = 16'($urandom);
            w.ack_long = 16'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 84) begin
                w.op = OP_SCAN;
                pick = $urandom_range(0, 99);
                if (pick < 12)
                    gen_raw = gen_raw ^ (16'd1 << $urandom_range(0, KEYS - 1));
                else if (pick < 14)
                    gen_raw = 16'($urandom);
                else if (pick < 16)
                    gen_raw = '0;
                w.raw = gen_raw;
                // contact bounce on one key for this scan only
                if ($urandom_range(0, 99) < 10)
                    w.raw = gen_raw ^ (16'd1 << $urandom_range(0, KEYS - 1));
                pick = $urandom_range(0, 99);
                if (pick < 75)
                    gen_now = gen_now + $urandom_range(0, int'(reg_debounce) / 2 + 2);
                else if (pick < 97)
                    gen_now = gen_now + $urandom_range(0, int'(reg_long) * 2 + 4);
                else
                    gen_now = $urandom;
                w.now = gen_now;
            end else if (pick < 92) begin
                w.op = OP_MARK;
            end else if (pick < 99) begin
                w.op = OP_ACK;
                if ($urandom_range(0, 4) == 0) begin
                    w.ack_tap = 16'hFFFF;
                    w.ack_long = 16'hFFFF;
                end
            end else begin
                w.op = OP_UNUSED;
            end
            pending_words.push_back(w);
        end
    endtask

    task automatic run_phase(input logic [15:0] deb, input logic [15:0] tap,
                             input logic [15:0] lng, input int idle, input int stall,
                             input int count, input logic [31:0] start_now);
        wait_drain();
        write_reg(CFG_DEBOUNCE, deb);
        write_reg(CFG_TAP, tap);
        write_reg(CFG_LONG, lng);
        @(negedge i_clk);
        send_idle_pct = idle;
        stall_pct = stall;
        gen_now = start_now;
        random_words(count);
    endtask

    initial begin : stimulus
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        // all keys pressed together, marked, then released without taps
        push_word(OP_SCAN, 16'h0000, 32'd0, 16'hFFFF, 16'hFFFF);
        push_word(OP_SCAN, 16'hFFFF, 32'd0, 16'h0000, 16'h0000);
        push_word(OP_SCAN, 16'hFFFF, 32'd8, 16'h1234, 16'h4321);
        push_word(OP_MARK, 16'hA5A5, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        push_word(OP_SCAN, 16'h0000, 32'd20, 16'h0000, 16'h0000);
        push_word(OP_SCAN, 16'h0000, 32'd28, 16'h0000, 16'h0000);
        // held key released while a higher key still shows down
        push_word(OP_SCAN, 16'h0200, 32'd100, 16'h0000, 16'h0000);
        push_word(OP_SCAN, 16'h0200, 32'd110, 16'h0000, 16'h0000);
        push_word(OP_SCAN, 16'h0204, 32'd120, 16'h0000, 16'h0000);
        push_word(OP_SCAN, 16'h0204, 32'd130, 16'h0000, 16'h0000);
        push_word(OP_SCAN, 16'h0000, 32'd140, 16'h0000, 16'h0000);
        push_word(OP_SCAN, 16'h0000, 32'd150, 16'h0000, 16'h0000);
        // held key released after a lower key went up in the same scan
        push_word(OP_SCAN, 16'h0013, 32'd160, 16'h0000, 16'h0000);
        push_word(OP_SCAN, 16'h0013, 32'd170, 16'h0000, 16'h0000);
        push_word(OP_SCAN, 16'h0001, 32'd180, 16'h0000, 16'h0000);
        push_word(OP_SCAN, 16'h0001, 32'd190, 16'h0000, 16'h0000);
        // long press
        push_word(OP_SCAN, 16'h0001, 32'd790, 16'h0000, 16'h0000);
        push_word(OP_ACK, 16'hFFFF, 32'd0, 16'h0002, 16'hFFFF);
        push_word(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        // time wraps through zero
        push_word(OP_SCAN, 16'h0001, 32'hFFFF_FFFF, 16'h0000, 16'h0000);
        push_word(OP_SCAN, 16'h8000, 32'hFFFF_FFFC, 16'h0000, 16'h0000);
        push_word(OP_SCAN, 16'h8000, 32'h0000_0004, 16'h0000, 16'h0000);
        push_word(OP_ACK, 16'h0000, 32'd0, 16'hFFFF, 16'hFFFF);

        run_phase(16'd2,     16'd40,    16'd90,    0,  0,  250, 32'd1000);
        run_phase(16'd0,     16'hFFFF,  16'd0,     88, 0,  200, 32'd5000);
        run_phase(16'hFFFF,  16'd0,     16'hFFFF,  0,  88, 150, 32'h0010_0000);
        run_phase(16'd5,     16'd300,   16'd400,   35, 35, 300, 32'h8000_0000);
        run_phase(16'd3,     16'd60,    16'd120,   0,  0,  300, 32'hFFFF_FF00);
        wait_drain();
        if (errors == 0 && expected_states.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin : watchdog
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
